>>> hw/rtl/nxgc_pkg.sv
// Shared types, constants and helpers for the grouped next-combination block.
// Used by nxgc_cfg, nxgc_lane, the top level and the port checker.
// No dependencies.
package nxgc_pkg;

  // pattern geometry
  localparam int PAT_W  = 64;
  localparam int GROUPS = 4;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 3;
  localparam int OFF_W  = $clog2(PAT_W) + 1;
  localparam int TZ_W   = $clog2(PAT_W);

  // register indexes
  localparam logic [IDX_W-1:0] REG_GROUP_COUNT  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GROUP_SIZE_0 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_GROUP_SIZE_1 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_GROUP_SIZE_2 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_GROUP_SIZE_3 = IDX_W'(4);

  // reset values of the registers
  localparam logic [CNT_W-1:0]  GROUP_COUNT_RST = CNT_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_0_RST      = SIZE_W'(PAT_W);
  localparam logic [SIZE_W-1:0] SIZE_N_RST      = SIZE_W'(1);

  // group placement, derived from the registers
  typedef struct packed {
    logic [GROUPS-1:0][PAT_W-1:0] gmask;  // bits of each group in place
    logic [GROUPS-1:0][PAT_W-1:0] incl;   // bits of groups 0..g
    logic [GROUPS-1:0][OFF_W-1:0] off;    // lowest bit of each group
    logic [PAT_W-1:0]             total;  // bits of all groups
  } nxgc_geom_t;

  // per-group step outcome
  typedef struct packed {
    logic             adv;     // group can advance
    logic [PAT_W-1:0] nslice;  // advanced group, in place
    logic [PAT_W-1:0] rst;     // group ones packed at its bottom, in place
  } nxgc_lane_t;

  // ones in bits below w (w up to PAT_W)
  function automatic logic [PAT_W-1:0] low_ones(input logic [OFF_W-1:0] w);
    logic [PAT_W-1:0] lo;
    lo = '0;
    for (int i = 0; i < PAT_W; i++) begin
      lo[i] = (OFF_W'(i) < w);
    end
    return lo;
  endfunction

  // bit index of a one-hot word
  function automatic logic [TZ_W-1:0] onehot_idx(input logic [PAT_W-1:0] v);
    logic [TZ_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < PAT_W; i++) begin
      if (v[i]) begin
        idx = idx | TZ_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/nxgc_cfg.sv
// Configuration registers and registered group placement (offsets and masks).
// Depends on nxgc_pkg.
module nxgc_cfg import nxgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output nxgc_geom_t        geom
);

  logic [CNT_W-1:0]              cnt_r;
  logic [GROUPS-1:0][SIZE_W-1:0] size_r;
  nxgc_geom_t                    geom_r;
  nxgc_geom_t                    geom_nxt;

  // write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= GROUP_COUNT_RST;
      size_r[0] <= SIZE_0_RST;
      for (int g = 1; g < GROUPS; g++) begin
        size_r[g] <= SIZE_N_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_COUNT:  cnt_r     <= cfg_data[CNT_W-1:0];
        REG_GROUP_SIZE_0: size_r[0] <= cfg_data;
        REG_GROUP_SIZE_1: size_r[1] <= cfg_data;
        REG_GROUP_SIZE_2: size_r[2] <= cfg_data;
        REG_GROUP_SIZE_3: size_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // place groups: clamp count and sizes, cut at the top of the pattern
  always_comb begin
    logic [CNT_W-1:0]  n;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] s;
    n = cnt_r;
    if (n == '0) begin
      n = CNT_W'(1);
    end else if (n > CNT_W'(GROUPS)) begin
      n = CNT_W'(GROUPS);
    end
    off      = '0;
    geom_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      s = size_r[g];
      if (s > SIZE_W'(PAT_W)) begin
        s = SIZE_W'(PAT_W);
      end
      if (CNT_W'(g) >= n) begin
        s = '0;
      end
      if (off >= OFF_W'(PAT_W)) begin
        s = '0;
      end else if (OFF_W'(s) > OFF_W'(PAT_W) - off) begin
        s = SIZE_W'(OFF_W'(PAT_W) - off);
      end
      geom_nxt.off[g]   = off;
      geom_nxt.incl[g]  = low_ones(off + OFF_W'(s));
      geom_nxt.gmask[g] = geom_nxt.incl[g] & ~low_ones(off);
      off = off + OFF_W'(s);
    end
    geom_nxt.total = low_ones(off);
  end

  // hold placement in registers to keep it off the data path
  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

>>> hw/rtl/nxgc_lane.sv
// One group of the pattern: Gosper step in place and the packed-bottom reset.
// Depends on nxgc_pkg.
module nxgc_lane import nxgc_pkg::*; (
  input  logic [PAT_W-1:0] pat,
  input  logic [PAT_W-1:0] gmask,
  input  logic [OFF_W-1:0] off,
  output nxgc_lane_t       lane
);

  logic [PAT_W-1:0] x;
  logic [PAT_W-1:0] xm1;
  logic [PAT_W-1:0] fill;
  logic [PAT_W-1:0] lsb;
  logic [PAT_W-1:0] u;
  logic [PAT_W-1:0] run_low;
  logic [TZ_W-1:0]  tz;
  logic [OFF_W-1:0] rel;
  logic [OFF_W-1:0] amt;

  // group bits in place and their lowest one
  assign x    = pat & gmask;
  assign xm1  = x - PAT_W'(1);
  assign fill = (x | xm1) & gmask;
  assign lsb  = x & ~xm1;
  assign tz   = onehot_idx(lsb);
  assign rel  = OFF_W'(tz) - off;

  // advance unless the ones are packed at the top or the group is empty
  assign lane.adv = (fill != gmask);

  // bump the lowest run, refill its remainder at the group bottom
  assign u       = x + lsb;
  assign amt     = rel + OFF_W'(2);
  assign run_low = ((x ^ u) >> amt) & gmask;
  assign lane.nslice = (u | run_low) & gmask;

  // exhausted group: same count of ones packed at the bottom
  assign lane.rst = (lsb != '0) ? ((gmask >> rel) & gmask) : '0;

endmodule

>>> hw/rtl/next_grouped_combination.sv
// Top level of the grouped next-combination block: input register, group lanes,
// priority merge and result register.
// Depends on nxgc_pkg, nxgc_cfg and nxgc_lane.

// One word is taken at every clock edge with start high and busy low, and its
// result appears on out_next_pattern/out_done_res with out_valid high for one
// cycle, after the input and result registers; a new word may start every
// cycle while busy is low. The path between the input and result registers
// is set by each group's two 64-bit carry chains (lowest one and run bump)
// followed by the trailing-zero shift. busy is high during reset and in the
// cycle after it. Register writes pass the configuration and placement
// registers, so a word started in the cycle after a write already uses it.
// The receiver cannot stall: results must be captured when out_valid is high.
module next_grouped_combination import nxgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [PAT_W-1:0]  in_pattern,
  output logic              out_valid,
  output logic [PAT_W-1:0]  out_next_pattern,
  output logic              out_done_res,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  nxgc_geom_t              geom;
  nxgc_lane_t [GROUPS-1:0] lanes;
  logic                    busy_r;
  logic                    accept;
  logic                    vld0_r;
  logic [PAT_W-1:0]        pat_r;
  logic [PAT_W-1:0]        pat;
  logic                    out_valid_r;
  logic [PAT_W-1:0]        next_r;
  logic [PAT_W-1:0]        next_nxt;
  logic                    done_r;
  logic                    done_nxt;

  nxgc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // hold busy for the cycle that loads the placement after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pat_r <= in_pattern;
    end
  end

  // drop bits beyond the configured groups
  assign pat = pat_r & geom.total;

  for (genvar g = 0; g < GROUPS; g++) begin : g_lane
    nxgc_lane u_lane (
      .pat   (pat),
      .gmask (geom.gmask[g]),
      .off   (geom.off[g]),
      .lane  (lanes[g])
    );
  end

  // advance the lowest group that can, reset all groups below it
  always_comb begin
    logic [PAT_W-1:0] acc;
    acc      = '0;
    done_nxt = 1'b1;
    next_nxt = '1;
    for (int g = 0; g < GROUPS; g++) begin
      if (done_nxt && lanes[g].adv) begin
        next_nxt = (pat & ~geom.incl[g]) | lanes[g].nslice | acc;
        done_nxt = 1'b0;
      end
      acc = acc | lanes[g].rst;
    end
  end

  // register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld0_r) begin
      next_r <= next_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pattern = next_r;
  assign out_done_res     = done_r;

endmodule

>>> hw/rtl/nxgc_chk.sv
// Port checker for next_grouped_combination: latency, done and busy rules.
// Depends on nxgc_pkg; bound to the top level at the end of this file.
module nxgc_chk import nxgc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [PAT_W-1:0] out_next_pattern,
  input logic             out_done_res
);

  // every accepted word yields a result through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // no result without a matching accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted word");

  // done result carries the all-ones pattern
  a_done_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_next_pattern == '1))
    else $error("done result is not all ones");

  // an advanced pattern always keeps a set bit
  a_next_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_next_pattern != '0))
    else $error("advanced pattern is empty");

  // busy only right after reset
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind next_grouped_combination nxgc_chk u_nxgc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_next_pattern (out_next_pattern),
  .out_done_res     (out_done_res)
);

>>> bench/next_grouped_combination_test.sv
// Self-checking bench for next_grouped_combination: directed table, then random
// enumeration walks and noise words under many group layouts.
// Depends on nxgc_pkg and the next_grouped_combination RTL.
module next_grouped_combination_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nxgc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 500;
  localparam int REPORT_MAX   = 10;
  localparam logic [PAT_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [PAT_W-1:0] nxt_pattern;
    logic             is_last;
  } successor_t;

  typedef struct packed {
    logic [SIZE_W-1:0]             count_data;
    logic [GROUPS-1:0][SIZE_W-1:0] sizes;
    logic [PAT_W-1:0]              pattern;
    logic                          fixed;
    logic [PAT_W-1:0]              want_pattern;
    logic                          want_last;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [PAT_W-1:0]  in_pattern = '0;
  logic              out_valid;
  logic [PAT_W-1:0]  out_next_pattern;
  logic              out_done_res;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // register copies and the group layout derived from them
  logic [CNT_W-1:0]  count_q = GROUP_COUNT_RST;
  logic [SIZE_W-1:0] size_q [GROUPS];
  int unsigned       grp_width [GROUPS];
  int unsigned       grp_base [GROUPS];
  int unsigned       grp_used;
  int unsigned       grp_total;

  logic [SIZE_W-1:0]             applied_count;
  logic [GROUPS-1:0][SIZE_W-1:0] applied_sizes;

  successor_t expected_successors [$];
  dir_row_t   directed_rows [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         words_sent = 0;
  bit         steady = 1'b0;

  next_grouped_combination dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pattern       (in_pattern),
    .out_valid        (out_valid),
    .out_next_pattern (out_next_pattern),
    .out_done_res     (out_done_res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [PAT_W-1:0] ones_below(input int unsigned w);
    if (w >= PAT_W) begin
      return '1;
    end
    return (64'd1 << w) - 64'd1;
  endfunction

  // position of the lowest one; PAT_W for a zero word
  function automatic int unsigned trailing_zeros(input logic [PAT_W-1:0] v);
    int unsigned n;
    n = PAT_W;
    for (int i = PAT_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = i;
      end
    end
    return n;
  endfunction

  // rebuild group offsets and widths: clamp count and sizes, cut at the top
  task automatic refresh_layout();
    int unsigned sz;
    int unsigned base;
    grp_used = (count_q == 0) ? 1 : ((count_q > GROUPS) ? GROUPS : count_q);
    base = 0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_base[g] = base;
      sz = (size_q[g] > PAT_W) ? PAT_W : size_q[g];
      if (g >= grp_used || base >= PAT_W) begin
        sz = 0;
      end else if (sz > PAT_W - base) begin
        sz = PAT_W - base;
      end
      grp_width[g] = sz;
      base += sz;
    end
    grp_total = base;
  endtask

  // advance the lowest group not packed at its top, repack the groups below it
  function automatic successor_t predict_successor(input logic [PAT_W-1:0] pat);
    logic [PAT_W-1:0] p, packed_low, m, slice, grp, fill, t, tlow, lowpart;
    successor_t r;
    bit found;
    p = pat & ones_below(grp_total);
    packed_low = '0;
    found = 1'b0;
    r.nxt_pattern = ALL_ONES;
    r.is_last = 1'b1;
    for (int g = 0; g < GROUPS; g++) begin
      if (!found && g < grp_used && grp_width[g] != 0) begin
        m = ones_below(grp_width[g]);
        slice = p >> grp_base[g];
        grp = slice & m;
        fill = slice | (slice - 64'd1);
        if ((fill & m) != m) begin
          t = fill + 64'd1;
          tlow = t & (~t + 64'd1);
          lowpart = ((tlow - 64'd1) >> trailing_zeros(slice)) >> 1;
          r.nxt_pattern = packed_low | ((t | lowpart) << grp_base[g]);
          r.is_last = 1'b0;
          found = 1'b1;
        end else if (grp != '0) begin
          packed_low |= (m >> trailing_zeros(grp)) << grp_base[g];
        end
      end
    end
    return r;
  endfunction

  // well-formed start of an enumeration walk: bits only inside the groups
  function automatic logic [PAT_W-1:0] walk_seed();
    logic [PAT_W-1:0] seed, piece;
    int unsigned w, k;
    seed = '0;
    for (int g = 0; g < GROUPS; g++) begin
      w = grp_width[g];
      if (w != 0) begin
        k = $urandom_range(w);
        case ($urandom_range(3))
          0: piece = {$urandom, $urandom} & ones_below(w);
          1: piece = ones_below(k);
          2: piece = ones_below(k) << (w - k);
          default: piece = {$urandom, $urandom} & {$urandom, $urandom} & ones_below(w);
        endcase
        seed |= piece << grp_base[g];
      end
    end
    return seed;
  endfunction

  function automatic dir_row_t mk_row(input logic [SIZE_W-1:0] cnt,
                                      input logic [SIZE_W-1:0] s0, s1, s2, s3,
                                      input logic [PAT_W-1:0] pat,
                                      input logic fixed,
                                      input logic [PAT_W-1:0] want,
                                      input logic want_last);
    dir_row_t r;
    r.count_data = cnt;
    r.sizes = {s3, s2, s1, s0};
    r.pattern = pat;
    r.fixed = fixed;
    r.want_pattern = want;
    r.want_last = want_last;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [PAT_W-1:0] want,
                               input logic [PAT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, field,
               want, got);
    end
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    successor_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_successors.size() == 0) begin
        note_mismatch("unexpected word", '0, out_next_pattern);
      end else begin
        want = expected_successors.pop_front();
        if (out_next_pattern !== want.nxt_pattern) begin
          note_mismatch("next_pattern", want.nxt_pattern, out_next_pattern);
        end
        if (out_done_res !== want.is_last) begin
          note_mismatch("done_res", PAT_W'(want.is_last), PAT_W'(out_done_res));
        end
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_GROUP_COUNT:  count_q = data[CNT_W-1:0];
      REG_GROUP_SIZE_0: size_q[0] = data;
      REG_GROUP_SIZE_1: size_q[1] = data;
      REG_GROUP_SIZE_2: size_q[2] = data;
      REG_GROUP_SIZE_3: size_q[3] = data;
      default: ;
    endcase
  endtask

  // drain, let the pipeline settle, then write all registers
  task automatic apply_config(input logic [SIZE_W-1:0] cnt,
                              input logic [GROUPS-1:0][SIZE_W-1:0] sizes);
    start <= 1'b0;
    while (expected_successors.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    write_reg(REG_GROUP_COUNT, cnt);
    write_reg(REG_GROUP_SIZE_0, sizes[0]);
    write_reg(REG_GROUP_SIZE_1, sizes[1]);
    write_reg(REG_GROUP_SIZE_2, sizes[2]);
    write_reg(REG_GROUP_SIZE_3, sizes[3]);
    cfg_we <= 1'b0;
    applied_count = cnt;
    applied_sizes = sizes;
    refresh_layout();
  endtask

  // offer one word, idling at random; hold start until accepted
  task automatic send_word(input logic [PAT_W-1:0] pat, input successor_t want);
    while (!steady && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pattern <= pat;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    expected_successors.push_back(want);
    words_sent++;
  endtask

  initial begin
    logic [GROUPS-1:0][SIZE_W-1:0] sizes;
    logic [SIZE_W-1:0] cnt;
    logic [PAT_W-1:0]  walk, pat;
    successor_t        want;
    dir_row_t          row;
    int                span;
    bit                in_walk;

    size_q[0] = SIZE_0_RST;
    size_q[1] = SIZE_N_RST;
    size_q[2] = SIZE_N_RST;
    size_q[3] = SIZE_N_RST;
    applied_count = SIZE_W'(GROUP_COUNT_RST);
    applied_sizes = {SIZE_N_RST, SIZE_N_RST, SIZE_N_RST, SIZE_0_RST};
    refresh_layout();

    // reset layout: one group of 64 bits
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'h0, 1, ALL_ONES, 1));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, ALL_ONES, 1, ALL_ONES, 1));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'h1, 1, 64'h2, 0));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'h3, 1, 64'h5, 0));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'h8000_0000_0000_0000, 1, ALL_ONES, 1));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0, 0));
    directed_rows.push_back(mk_row(1, 64, 1, 1, 1, 64'hF000_0000_0000_0000, 1, ALL_ONES, 1));
    // four groups of 16
    directed_rows.push_back(mk_row(4, 16, 16, 16, 16, 64'h0001_0001_0001_0001, 0, '0, 0));
    directed_rows.push_back(mk_row(4, 16, 16, 16, 16, 64'h8000_8000_8000_8000, 1, ALL_ONES, 1));
    directed_rows.push_back(mk_row(4, 16, 16, 16, 16, 64'h8000_8000_8000_0001, 0, '0, 0));
    // upper groups start past the top
    directed_rows.push_back(mk_row(4, 64, 64, 64, 64, 64'h5, 0, '0, 0));
    // bits above two small groups read as zero
    directed_rows.push_back(mk_row(2, 4, 4, 1, 1, 64'hFFFF_FFFF_FFFF_FF18, 0, '0, 0));
    directed_rows.push_back(mk_row(2, 4, 4, 1, 1, 64'h88, 1, ALL_ONES, 1));
    // count zero acts as one
    directed_rows.push_back(mk_row(0, 3, 5, 5, 5, 64'h3, 0, '0, 0));
    // count above range with an empty lowest group
    directed_rows.push_back(mk_row(7, 0, 2, 2, 2, 64'h1, 0, '0, 0));
    directed_rows.push_back(mk_row(7, 0, 2, 2, 2, 64'h0, 1, ALL_ONES, 1));
    // oversize group acts as 64
    directed_rows.push_back(mk_row(3, 127, 1, 1, 1, 64'h6, 0, '0, 0));
    // single-bit groups
    directed_rows.push_back(mk_row(4, 1, 1, 1, 1, 64'hF, 1, ALL_ONES, 1));
    directed_rows.push_back(mk_row(4, 1, 1, 1, 1, 64'h5, 0, '0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.count_data != applied_count || row.sizes != applied_sizes) begin
        apply_config(row.count_data, row.sizes);
      end
      if (row.fixed) begin
        want.nxt_pattern = row.want_pattern;
        want.is_last = row.want_last;
      end else begin
        want = predict_successor(row.pattern);
      end
      send_word(row.pattern, want);
    end

    // random phases: mostly enumeration walks, some noise words
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(9))
        0: begin
          cnt = SIZE_W'($urandom_range(1, 7));
          sizes = {7'd64, 7'd64, 7'd64, 7'd64};
        end
        1: begin
          cnt = SIZE_W'($urandom_range(127));
          for (int g = 0; g < GROUPS; g++) begin
            sizes[g] = SIZE_W'($urandom_range(127));
          end
        end
        default: begin
          cnt = SIZE_W'($urandom_range(1, GROUPS));
          for (int g = 0; g < GROUPS; g++) begin
            sizes[g] = SIZE_W'(($urandom_range(7) == 0) ? $urandom_range(1, 20)
                                                         : $urandom_range(1, 6));
          end
        end
      endcase
      apply_config(cnt, sizes);
      walk = walk_seed();
      span = $urandom_range(20, 60);
      for (int n = 0; n < span; n++) begin
        steady = (words_sent >= 200 && words_sent < 300);
        in_walk = ($urandom_range(9) < 7);
        if (in_walk) begin
          pat = walk;
        end else begin
          case ($urandom_range(2))
            0: pat = {$urandom, $urandom};
            1: pat = walk ^ (64'd1 << $urandom_range(PAT_W - 1));
            default: pat = walk | ~ones_below(grp_total);
          endcase
        end
        want = predict_successor(pat);
        send_word(pat, want);
        // follow the enumeration, restart it once exhausted
        if (in_walk) begin
          walk = want.is_last ? walk_seed() : want.nxt_pattern;
        end
      end
    end
    steady = 1'b0;
    start <= 1'b0;

    while (expected_successors.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
